// ===== design/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, codes and the arctangent table of the touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int XY_W       = 12;
	localparam int ANG_W      = 16;
	localparam int MUL_W      = 18;

	// request types
	localparam logic [1:0] REQ_DOWN = 2'd0;
	localparam logic [1:0] REQ_UP   = 2'd1;
	localparam logic [1:0] REQ_MOVE = 2'd2;
	localparam logic [1:0] REQ_TICK = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DTAP_MS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PINCH_THR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_THR   = 3'd6;

	// gesture modes
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_TAP   = 3'd1;
	localparam logic [2:0] M_DRAG  = 3'd2;
	localparam logic [2:0] M_LONG  = 3'd3;
	localparam logic [2:0] M_PINCH = 3'd4;

	// event kinds
	localparam logic [3:0] EV_LPRESS = 4'd0;
	localparam logic [3:0] EV_LREL   = 4'd1;
	localparam logic [3:0] EV_RPRESS = 4'd2;
	localparam logic [3:0] EV_RREL   = 4'd3;
	localparam logic [3:0] EV_MOVE   = 4'd4;
	localparam logic [3:0] EV_ZIN    = 4'd5;
	localparam logic [3:0] EV_ZOUT   = 4'd6;
	localparam logic [3:0] EV_ROTP   = 4'd7;
	localparam logic [3:0] EV_ROTN   = 4'd8;

	localparam logic [ANG_W-1:0] ANG_HALF = 16'd32768;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] finger_id;
		logic [15:0] x_frac;
		logic [15:0] y_frac;
		logic [31:0] event_time;
		logic        on_widget;
	} req_t;

	typedef struct packed {
		logic [3:0]      event_kind;
		logic [XY_W-1:0] out_x;
		logic [XY_W-1:0] out_y;
		logic            last;
	} evt_t;

	// atan(2^-i) in binary angle units, 65536 per turn
	function automatic logic [ANG_W-1:0] atan_step(input logic [4:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0: a = 16'd8192;
			5'd1: a = 16'd4836;
			5'd2: a = 16'd2555;
			5'd3: a = 16'd1297;
			5'd4: a = 16'd651;
			5'd5: a = 16'd326;
			5'd6: a = 16'd163;
			5'd7: a = 16'd81;
			5'd8: a = 16'd41;
			5'd9: a = 16'd20;
			5'd10: a = 16'd10;
			5'd11: a = 16'd5;
			5'd12: a = 16'd3;
			5'd13: a = 16'd1;
			5'd14: a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

	function automatic evt_t mk_evt(input logic [3:0] k, input logic [XY_W-1:0] x,
			input logic [XY_W-1:0] y);
		evt_t e;
		e.event_kind = k;
		e.out_x = x;
		e.out_y = y;
		e.last = 1'b0;
		return e;
	endfunction

endpackage

// ===== design/tgr_isqrt.sv =====
// ----------------------------------------------------------------------------
// tgr_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tgr_isqrt
	import tgr_pkg::*;
#(
	parameter int OUT_W = 13,
	parameter int IN_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  radicand,
	output logic             busy,
	output logic [OUT_W-1:0] root
);

	localparam int REMW = OUT_W + 4;
	localparam int CW = $clog2(OUT_W);

	logic [IN_W-1:0]  n_q;
	logic [REMW-1:0]  rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CW-1:0]    i_q;
	logic             busy_q;
	logic [REMW-1:0]  rem_sh;
	logic [REMW-1:0]  trial;
	logic             fits;

	assign rem_sh = {rem_q[REMW-3:0], n_q[IN_W-1 -: 2]};
	assign trial  = REMW'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			if (i_q == CW'(OUT_W - 1)) begin
				busy_q <= 1'b0;
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[IN_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[OUT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[OUT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== design/tgr_cordic.sv =====
// ----------------------------------------------------------------------------
// tgr_cordic
// Iterative vectoring CORDIC giving the angle of (dx, dy) in binary units.
// ----------------------------------------------------------------------------
module tgr_cordic
	import tgr_pkg::*;
#(
	parameter int IN_W = 13,
	parameter int STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [IN_W-1:0] dx,
	input  logic signed [IN_W-1:0] dy,
	output logic                   busy,
	output logic [ANG_W-1:0]       angle
);

	localparam int XW = IN_W + 11;
	localparam int SW = $clog2(STEPS);

	logic signed [XW-1:0] x_q, y_q, xs, ys, x0, y0;
	logic [ANG_W-1:0]     z_q;
	logic [SW-1:0]        i_q;
	logic                 busy_q;

	// one shared barrel shift per coordinate
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign x0 = XW'(dx) <<< 8;
	assign y0 = XW'(dy) <<< 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= '0;
		end else if (busy_q) begin
			if (i_q == SW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= ANG_HALF;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_step(5'(i_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_step(5'(i_q));
			end
		end
	end

	assign busy = busy_q;
	assign angle = z_q;

endmodule

// ===== design/touch_gesture_recognizer_top.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top
// Two-finger gesture recognizer: tap, drag, long press, pinch and rotate.
// ----------------------------------------------------------------------------
// One request is handled at a time. Down, up, tick and non-pinch motion
// requests pass through the scaling, lookup, squared-distance, threshold,
// execute and load states, which use the shared 18x18 multiplier for scaling
// and squared distances. A pinch start or pinch motion adds the difference,
// squaring, start, wait and finish states, in which the bit-serial square
// root and the CORDIC run side by side. Up to two result events per request
// wait in an output buffer; the next request is taken while they drain.
module touch_gesture_recognizer_top
	import tgr_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int ID_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  evt_valid,
	input  logic                  evt_stall,
	output evt_t                  evt,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int RW = CB + 1;
	localparam int AW = 2 * RW;
	localparam logic [31:0] CMAX32 = (32'd1 << CB) - 32'd1;

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_SCX   = 15'h0002,
		S_SCY   = 15'h0004,
		S_LOOK  = 15'h0008,
		S_D2X   = 15'h0010,
		S_D2Y   = 15'h0020,
		S_THR   = 15'h0040,
		S_EXEC  = 15'h0080,
		S_PDIF  = 15'h0100,
		S_PSQX  = 15'h0200,
		S_PSQY  = 15'h0400,
		S_PGO   = 15'h0800,
		S_PWAIT = 15'h1000,
		S_PFIN  = 15'h2000,
		S_LOAD  = 15'h4000
	} state_t;

	state_t state_q;

	// configuration
	logic [12:0] cw_q, ch_q;
	logic [7:0]  drag_q;
	logic [15:0] lp_q, dtap_q;
	logic [11:0] pthr_q;
	logic [14:0] rthr_q;

	// gesture state
	logic [2:0]             mode_q;
	logic [1:0]             count_q;
	logic                   widget_q;
	logic [RW-1:0]          refd_q;
	logic [ANG_W-1:0]       refa_q;
	logic signed [17:0]     rot_q;
	logic [31:0]            ltt_q;
	logic [CB-1:0]          ltx_q, lty_q;
	logic                   pinit_q;
	logic                   idx_q;

	// finger slots
	logic [ID_BITS-1:0] id_q [2];
	logic [CB-1:0]      sx_q [2];
	logic [CB-1:0]      sy_q [2];
	logic [CB-1:0]      cx_q [2];
	logic [CB-1:0]      cy_q [2];
	logic [31:0]        dt_q [2];

	// working registers
	req_t                 req_q;
	logic [CB-1:0]        px_q, py_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [AW-1:0]        acc_q;
	logic [15:0]          thr2_q;
	evt_t                 st_q [2];
	logic [1:0]           st_n_q;
	evt_t                 ob_q [2];
	logic [1:0]           ob_cnt_q;
	logic                 ob_rd_q;

	logic req_acc, evt_acc;
	assign req_acc   = req_valid && !req_stall;
	assign evt_acc   = evt_valid && !evt_stall;
	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign evt_valid = (ob_cnt_q != 2'd0);
	assign evt       = ob_q[ob_rd_q];

	// shared multiplier
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SCX: begin
				mul_a = MUL_W'({1'b0, req_q.x_frac});
				mul_b = MUL_W'({1'b0, cw_q});
			end
			S_SCY: begin
				mul_a = MUL_W'({1'b0, req_q.y_frac});
				mul_b = MUL_W'({1'b0, ch_q});
			end
			S_D2X, S_PSQX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_D2Y, S_PSQY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			S_THR: begin
				mul_a = MUL_W'({1'b0, drag_q});
				mul_b = MUL_W'({1'b0, drag_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	logic [31:0]   scl32;
	logic [CB-1:0] scl;
	assign scl32 = 32'(mul_p[28:16]);
	assign scl   = (scl32 > CMAX32) ? CB'(CMAX32) : CB'(scl32);

	// finger lookup
	logic [ID_BITS-1:0] id_in;
	logic               m0, m1, found;
	assign id_in = ID_BITS'(req_q.finger_id);
	assign m0    = (count_q != 2'd0) && (id_q[0] == id_in);
	assign m1    = (count_q == 2'd2) && (id_q[1] == id_in);
	assign found = m0 || m1;

	logic ignore;
	always_comb begin
		case (req_q.req_type)
			REQ_DOWN: ignore = (count_q == 2'd2);
			REQ_UP, REQ_MOVE: ignore = !found;
			default: ignore = 1'b0;
		endcase
	end

	// decisions
	logic [31:0] tap_gap, hold_time;
	logic        dbl_tap, drag_go, lp_go;
	assign tap_gap   = req_q.event_time - ltt_q;
	assign hold_time = req_q.event_time - dt_q[0];
	assign dbl_tap   = (ltt_q != 32'd0) && (tap_gap < {16'd0, dtap_q})
		&& (acc_q < AW'(thr2_q));
	assign drag_go   = (acc_q > AW'(thr2_q));
	assign lp_go     = (mode_q == M_TAP) && !widget_q && (count_q == 2'd1)
		&& (hold_time > {16'd0, lp_q});

	logic [XY_W-1:0] pxo, pyo, c0x, c0y, s0x, s0y;
	assign pxo = XY_W'(px_q);
	assign pyo = XY_W'(py_q);
	assign c0x = XY_W'(cx_q[0]);
	assign c0y = XY_W'(cy_q[0]);
	assign s0x = XY_W'(sx_q[0]);
	assign s0y = XY_W'(sy_q[0]);

	logic [1:0] ex_n;
	evt_t       ex_e [2];

	always_comb begin
		ex_n = 2'd0;
		ex_e[0] = '0;
		ex_e[1] = '0;
		case (req_q.req_type)
			REQ_DOWN: begin
				if (count_q == 2'd0) begin
					ex_n = 2'd1;
					ex_e[0] = mk_evt(req_q.on_widget ? EV_LPRESS : EV_MOVE, pxo, pyo);
				end else if (mode_q == M_DRAG) begin
					ex_n = 2'd1;
					ex_e[0] = mk_evt(widget_q ? EV_LREL : EV_RREL, c0x, c0y);
				end else if (mode_q == M_TAP && widget_q) begin
					ex_n = 2'd1;
					ex_e[0] = mk_evt(EV_LREL, c0x, c0y);
				end
			end
			REQ_UP: begin
				if (mode_q == M_TAP) begin
					if (dbl_tap) begin
						if (widget_q) begin
							ex_n = 2'd2;
							ex_e[0] = mk_evt(EV_LREL, pxo, pyo);
							ex_e[1] = mk_evt(EV_ZIN, pxo, pyo);
						end else begin
							ex_n = 2'd1;
							ex_e[0] = mk_evt(EV_ZIN, pxo, pyo);
						end
					end else if (widget_q) begin
						ex_n = 2'd1;
						ex_e[0] = mk_evt(EV_LREL, pxo, pyo);
					end else begin
						ex_n = 2'd2;
						ex_e[0] = mk_evt(EV_LPRESS, pxo, pyo);
						ex_e[1] = mk_evt(EV_LREL, pxo, pyo);
					end
				end else if (mode_q == M_DRAG) begin
					ex_n = 2'd1;
					ex_e[0] = mk_evt(widget_q ? EV_LREL : EV_RREL, pxo, pyo);
				end
			end
			REQ_MOVE: begin
				if (mode_q == M_TAP) begin
					if (drag_go && !widget_q) begin
						ex_n = 2'd2;
						ex_e[0] = mk_evt(EV_RPRESS, s0x, s0y);
						ex_e[1] = mk_evt(EV_MOVE, pxo, pyo);
					end else begin
						ex_n = 2'd1;
						ex_e[0] = mk_evt(EV_MOVE, pxo, pyo);
					end
				end else if (mode_q == M_DRAG) begin
					ex_n = 2'd1;
					ex_e[0] = mk_evt(EV_MOVE, pxo, pyo);
				end
			end
			REQ_TICK: begin
				if (lp_go) begin
					ex_n = 2'd2;
					ex_e[0] = mk_evt(EV_RPRESS, c0x, c0y);
					ex_e[1] = mk_evt(EV_RREL, c0x, c0y);
				end
			end
			default: begin
				ex_n = 2'd0;
			end
		endcase
	end

	// pinch units
	logic             sq_busy, co_busy, unit_go;
	logic [RW-1:0]    root;
	logic [ANG_W-1:0] ang;
	assign unit_go = (state_q == S_PGO);

	tgr_isqrt #(
		.OUT_W(RW),
		.IN_W(AW)
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(unit_go),
		.radicand(acc_q),
		.busy(sq_busy),
		.root(root)
	);

	tgr_cordic #(
		.IN_W(DW),
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(unit_go),
		.dx(dx_q),
		.dy(dy_q),
		.busy(co_busy),
		.angle(ang)
	);

	// pinch decisions
	logic signed [31:0]    zdiff, pthr32;
	logic                  zoom_go, rot_go;
	logic signed [15:0]    dang;
	logic signed [18:0]    sum19;
	logic signed [17:0]    sat;
	logic signed [19:0]    s20, rthr20;
	evt_t                  zoom_e, rot_e;

	assign zdiff   = 32'(root) - 32'(refd_q);
	assign pthr32  = 32'(pthr_q);
	assign zoom_go = (zdiff > pthr32) || (-zdiff > pthr32);
	assign dang    = ang - refa_q;
	assign sum19   = 19'(rot_q) + 19'(dang);
	assign sat     = (sum19 > 19'sd131071) ? 18'sd131071
		: (sum19 < -19'sd131072) ? -18'sd131072 : 18'(sum19);
	assign s20     = 20'(sat);
	assign rthr20  = 20'(rthr_q);
	assign rot_go  = (s20 > rthr20) || (-s20 > rthr20);
	assign zoom_e  = mk_evt((zdiff > 0) ? EV_ZIN : EV_ZOUT, pxo, pyo);
	assign rot_e   = mk_evt((s20 > 0) ? EV_ROTP : EV_ROTN, pxo, pyo);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cw_q <= 13'd640;
			ch_q <= 13'd480;
			drag_q <= 8'd8;
			lp_q <= 16'd500;
			dtap_q <= 16'd300;
			pthr_q <= 12'd64;
			rthr_q <= 15'd5461;
			mode_q <= M_IDLE;
			count_q <= 2'd0;
			widget_q <= 1'b0;
			refd_q <= '0;
			refa_q <= '0;
			rot_q <= '0;
			ltt_q <= '0;
			ltx_q <= '0;
			lty_q <= '0;
			pinit_q <= 1'b0;
			st_n_q <= 2'd0;
			ob_cnt_q <= 2'd0;
			ob_rd_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCREEN_W: cw_q <= cfg_data[12:0];
					CFG_SCREEN_H: ch_q <= cfg_data[12:0];
					CFG_DRAG_THR: drag_q <= cfg_data[7:0];
					CFG_LONG_MS: lp_q <= cfg_data;
					CFG_DTAP_MS: dtap_q <= cfg_data;
					CFG_PINCH_THR: pthr_q <= cfg_data[11:0];
					CFG_ROT_THR: rthr_q <= cfg_data[14:0];
					default: ;
				endcase
			end

			if (evt_acc) begin
				ob_cnt_q <= ob_cnt_q - 2'd1;
				ob_rd_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_SCX;
					end
				end
				S_SCX: state_q <= S_SCY;
				S_SCY: state_q <= S_LOOK;
				S_LOOK: state_q <= ignore ? S_IDLE : S_D2X;
				S_D2X: state_q <= S_D2Y;
				S_D2Y: state_q <= S_THR;
				S_THR: state_q <= S_EXEC;
				S_EXEC: begin
					st_n_q <= ex_n;
					state_q <= S_LOAD;
					case (req_q.req_type)
						REQ_DOWN: begin
							count_q <= count_q + 2'd1;
							if (count_q == 2'd0) begin
								mode_q <= M_TAP;
								widget_q <= req_q.on_widget;
							end else begin
								rot_q <= '0;
								mode_q <= M_PINCH;
								pinit_q <= 1'b1;
								state_q <= S_PDIF;
							end
						end
						REQ_UP: begin
							if (mode_q == M_TAP) begin
								if (dbl_tap) begin
									ltt_q <= '0;
								end else begin
									ltt_q <= req_q.event_time;
									ltx_q <= px_q;
									lty_q <= py_q;
								end
							end
							count_q <= count_q - 2'd1;
							if (count_q == 2'd1 || mode_q == M_PINCH) begin
								mode_q <= M_IDLE;
							end
						end
						REQ_MOVE: begin
							if (mode_q == M_TAP && drag_go) begin
								mode_q <= M_DRAG;
							end
							if (mode_q == M_PINCH) begin
								pinit_q <= 1'b0;
								state_q <= S_PDIF;
							end
						end
						REQ_TICK: begin
							if (lp_go) begin
								mode_q <= M_LONG;
							end
						end
						default: ;
					endcase
				end
				S_PDIF: state_q <= S_PSQX;
				S_PSQX: state_q <= S_PSQY;
				S_PSQY: state_q <= S_PGO;
				S_PGO: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (!sq_busy && !co_busy) begin
						state_q <= S_PFIN;
					end
				end
				S_PFIN: begin
					refa_q <= ang;
					state_q <= S_LOAD;
					if (pinit_q) begin
						refd_q <= root;
					end else begin
						if (zoom_go) begin
							refd_q <= root;
						end
						rot_q <= rot_go ? 18'sd0 : sat;
						st_n_q <= 2'({1'b0, zoom_go}) + 2'({1'b0, rot_go});
					end
				end
				S_LOAD: begin
					if (st_n_q == 2'd0) begin
						state_q <= S_IDLE;
					end else if (ob_cnt_q == 2'd0) begin
						ob_cnt_q <= st_n_q;
						ob_rd_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					req_q <= req;
				end
			end
			S_SCX: px_q <= scl;
			S_SCY: py_q <= scl;
			S_LOOK: begin
				idx_q <= !m0;
				if (req_q.req_type == REQ_UP) begin
					dx_q <= $signed({1'b0, px_q}) - $signed({1'b0, ltx_q});
					dy_q <= $signed({1'b0, py_q}) - $signed({1'b0, lty_q});
				end else begin
					dx_q <= $signed({1'b0, px_q}) - $signed({1'b0, sx_q[0]});
					dy_q <= $signed({1'b0, py_q}) - $signed({1'b0, sy_q[0]});
				end
			end
			S_D2X, S_PSQX: acc_q <= AW'(mul_p);
			S_D2Y, S_PSQY: acc_q <= acc_q + AW'(mul_p);
			S_THR: thr2_q <= 16'(mul_p);
			S_EXEC: begin
				st_q[0] <= ex_e[0];
				st_q[1] <= ex_e[1];
				case (req_q.req_type)
					REQ_DOWN: begin
						id_q[count_q[0]] <= id_in;
						sx_q[count_q[0]] <= px_q;
						sy_q[count_q[0]] <= py_q;
						cx_q[count_q[0]] <= px_q;
						cy_q[count_q[0]] <= py_q;
						dt_q[count_q[0]] <= req_q.event_time;
					end
					REQ_UP: begin
						if (!idx_q && count_q == 2'd2) begin
							id_q[0] <= id_q[1];
							sx_q[0] <= sx_q[1];
							sy_q[0] <= sy_q[1];
							cx_q[0] <= cx_q[1];
							cy_q[0] <= cy_q[1];
							dt_q[0] <= dt_q[1];
						end
					end
					REQ_MOVE: begin
						cx_q[idx_q] <= px_q;
						cy_q[idx_q] <= py_q;
					end
					default: ;
				endcase
			end
			S_PDIF: begin
				dx_q <= $signed({1'b0, cx_q[1]}) - $signed({1'b0, cx_q[0]});
				dy_q <= $signed({1'b0, cy_q[1]}) - $signed({1'b0, cy_q[0]});
			end
			S_PFIN: begin
				if (!pinit_q) begin
					if (zoom_go) begin
						st_q[0] <= zoom_e;
						st_q[1] <= rot_e;
					end else begin
						st_q[0] <= rot_e;
					end
				end
			end
			S_LOAD: begin
				if (ob_cnt_q == 2'd0) begin
					ob_q[0] <= {st_q[0][$bits(evt_t)-1:1], (st_n_q == 2'd1)};
					ob_q[1] <= {st_q[1][$bits(evt_t)-1:1], 1'b1};
				end
			end
			default: ;
		endcase
	end

	// checks
	a_ob_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("finger count out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == S_SCX)
		else $error("accepted request not started");

	a_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PGO |=> sq_busy && co_busy)
		else $error("pinch units did not start");

	a_pinch_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PFIN |-> mode_q == M_PINCH)
		else $error("pinch finish outside pinch mode");

endmodule
